### rtl/core/hjrb_pkg.sv
// ----------------------------------------------------------------------------
// hjrb_pkg: shared types and constants for the joystick report builder
// Action codes, register map, controller-to-datapath command bundle and the
// hat-angle encoding helper.
// ----------------------------------------------------------------------------
package hjrb_pkg;

    localparam int AXIS_SLOTS = 11;
    localparam int MAX_HATS   = 2;
    localparam int SLOT_W     = 4;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [2:0] {
        ACT_SET_BUTTON = 3'd0,
        ACT_SET_AXIS   = 3'd1,
        ACT_SET_HAT    = 3'd2,
        ACT_SET_RANGE  = 3'd3,
        ACT_SEND       = 3'd4
    } action_t;

    // register map (word index = paddr[3:2])
    localparam logic [1:0] REG_BUTTON_COUNT = 2'd0;
    localparam logic [1:0] REG_HAT_COUNT    = 2'd1;
    localparam logic [1:0] REG_AXIS_MASK    = 2'd2;
    localparam logic [1:0] REG_AUTO_SEND    = 2'd3;

    localparam logic [5:0]  BUTTON_COUNT_RST = 6'd32;
    localparam logic [1:0]  HAT_COUNT_RST    = 2'd2;
    localparam logic [10:0] AXIS_MASK_RST    = 11'h7FF;
    localparam logic        AUTO_SEND_RST    = 1'b1;

    localparam logic signed [15:0] HAT_RELEASED   = -16'sd1;
    localparam logic signed [15:0] RANGE_HIGH_RST = 16'sd1023;
    localparam logic [15:0]        AXIS_MIN_WORD  = 16'h8001;   // -32767
    localparam logic [3:0]         HAT_CODE_IDLE  = 4'd8;

    // floor(a / 45) = (a * 46604) >> 21, exact for a < 2^15
    localparam logic [15:0] DIV45_MULT  = 16'd46604;
    localparam int          DIV45_SHIFT = 21;

    typedef enum logic [1:0] {
        SRC_BUTTON  = 2'd0,
        SRC_HAT     = 2'd1,
        SRC_AXIS_LO = 2'd2,
        SRC_AXIS_HI = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic              accept;
        logic              prep;
        logic              div_load;
        logic              div_step;
        logic              emit;
        logic              last;
        byte_src_t         src;
        logic [SLOT_W-1:0] slot;
    } hjrb_cmd_t;

    // (angle mod 360) / 45 equals floor(angle / 45) mod 8
    function automatic logic [3:0] hat_code(input logic signed [15:0] angle);
        logic [30:0] prod;
        prod = 31'(angle[14:0]) * 31'(DIV45_MULT);
        if (angle[15])
            return HAT_CODE_IDLE;
        return {1'b0, prod[DIV45_SHIFT+2:DIV45_SHIFT]};
    endfunction

endpackage

### rtl/core/hjrb_datapath.sv
// ----------------------------------------------------------------------------
// hjrb_datapath: report state storage, axis scaling and output register
// Holds buttons, hats, axes and ranges; clamps and scales one axis at a time
// through a bit-serial restoring divider; registers each report byte.
// ----------------------------------------------------------------------------
module hjrb_datapath #(
    parameter int MAX_BUTTONS = 32,
    localparam int BTN_BYTES  = (MAX_BUTTONS + 7) / 8,
    localparam int BIW        = (BTN_BYTES > 1) ? $clog2(BTN_BYTES) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hjrb_pkg::hjrb_cmd_t    cmd,
    input  logic [BIW-1:0]         btn_sel,
    input  logic [2:0]             action,
    input  logic [4:0]             index,
    input  logic signed [15:0]     value,
    input  logic signed [15:0]     range_end,
    input  logic [5:0]             button_count,
    input  logic [1:0]             hat_count,
    output logic                   upd_ok,
    output logic [7:0]             report_byte,
    output logic                   last_byte,
    output logic                   report_valid
);

    logic [7:0]         btn_bytes_reg [BTN_BYTES];
    logic signed [15:0] hat_reg       [hjrb_pkg::MAX_HATS];
    logic signed [15:0] axis_val_reg  [hjrb_pkg::AXIS_SLOTS];
    logic signed [15:0] rlo_reg       [hjrb_pkg::AXIS_SLOTS];
    logic signed [15:0] rhi_reg       [hjrb_pkg::AXIS_SLOTS];

    logic [15:0] x_reg;
    logic [15:0] d_reg;
    logic        empty_reg;
    logic [15:0] rem_reg;
    logic [15:0] q_reg;

    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        valid_reg;

    logic btn_ok;
    logic axis_ok;
    logic hat_ok;
    logic rng_ok;

    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] v;
    logic signed [15:0] rmin;
    logic signed [15:0] rmax;
    logic signed [15:0] vc;
    logic signed [16:0] x_full;
    logic signed [16:0] d_full;
    logic [31:0]        num;
    logic [16:0]        r17;
    logic [16:0]        r17_sub;
    logic [15:0]        word;
    logic [7:0]         byte_mux;

    // update qualification
    always_comb
    begin
        btn_ok  = (action == hjrb_pkg::ACT_SET_BUTTON) && ({1'b0, index} < button_count)
                  && (int'(index) < MAX_BUTTONS);
        axis_ok = (action == hjrb_pkg::ACT_SET_AXIS) && (index < 5'(hjrb_pkg::AXIS_SLOTS));
        hat_ok  = (action == hjrb_pkg::ACT_SET_HAT) && (index < {3'd0, hat_count})
                  && (index < 5'(hjrb_pkg::MAX_HATS));
        rng_ok  = (action == hjrb_pkg::ACT_SET_RANGE) && (index < 5'(hjrb_pkg::AXIS_SLOTS));
        upd_ok  = btn_ok || axis_ok || hat_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BTN_BYTES; b++)
                btn_bytes_reg[b] <= '0;
            for (int h = 0; h < hjrb_pkg::MAX_HATS; h++)
                hat_reg[h] <= hjrb_pkg::HAT_RELEASED;
            for (int a = 0; a < hjrb_pkg::AXIS_SLOTS; a++)
            begin
                axis_val_reg[a] <= '0;
                rlo_reg[a]      <= '0;
                rhi_reg[a]      <= hjrb_pkg::RANGE_HIGH_RST;
            end
        end
        else if (cmd.accept)
        begin
            for (int b = 0; b < BTN_BYTES; b++)
                if (btn_ok && (int'(index[4:3]) == b))
                    btn_bytes_reg[b][index[2:0]] <= (value != 16'sd0);
            if (hat_ok)
                hat_reg[index[0]] <= value;
            if (axis_ok)
                axis_val_reg[index[3:0]] <= value;
            if (rng_ok)
            begin
                rlo_reg[index[3:0]] <= value;
                rhi_reg[index[3:0]] <= range_end;
            end
        end
    end

    // clamp, reflect and offset of the selected axis
    always_comb
    begin
        lo     = rlo_reg[cmd.slot];
        hi     = rhi_reg[cmd.slot];
        v      = axis_val_reg[cmd.slot];
        rmin   = (lo < hi) ? lo : hi;
        rmax   = (lo < hi) ? hi : lo;
        vc     = (v < rmin) ? rmin : ((v > rmax) ? rmax : v);
        x_full = (lo > hi) ? (17'(rmax) - 17'(vc)) : (17'(vc) - 17'(rmin));
        d_full = 17'(rmax) - 17'(rmin);
        // x * 65534 = (x << 16) - (x << 1)
        num     = {x_reg, 16'd0} - {15'd0, x_reg, 1'b0};
        r17     = {rem_reg, q_reg[15]};
        r17_sub = r17 - {1'b0, d_reg};
        word    = (empty_reg ? 16'd0 : q_reg) + hjrb_pkg::AXIS_MIN_WORD;
    end

    // quotient < 2^16 because x <= d, so 16 steps cover it
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            x_reg     <= x_full[15:0];
            d_reg     <= d_full[15:0];
            empty_reg <= (lo == hi);
        end
        if (cmd.div_load)
        begin
            rem_reg <= num[31:16];
            q_reg   <= num[15:0];
        end
        else if (cmd.div_step)
        begin
            if (r17 >= {1'b0, d_reg})
            begin
                rem_reg <= r17_sub[15:0];
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= r17[15:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        case (cmd.src)
            hjrb_pkg::SRC_BUTTON:  byte_mux = btn_bytes_reg[btn_sel];
            hjrb_pkg::SRC_HAT:     byte_mux = {hjrb_pkg::hat_code(hat_reg[1]),
                                               hjrb_pkg::hat_code(hat_reg[0])};
            hjrb_pkg::SRC_AXIS_LO: byte_mux = word[7:0];
            hjrb_pkg::SRC_AXIS_HI: byte_mux = word[15:8];
            default:               byte_mux = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            last_reg  <= cmd.emit && cmd.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            byte_reg <= byte_mux;
    end

    assign report_byte  = byte_reg;
    assign last_byte    = last_reg;
    assign report_valid = valid_reg;

endmodule

### rtl/core/hjrb_ctrl.sv
// ----------------------------------------------------------------------------
// hjrb_ctrl: report sequencer
// Accepts commands, decides whether a report goes out, and walks the button
// bytes, hat byte and enabled axes, driving the datapath one step a cycle.
// ----------------------------------------------------------------------------
module hjrb_ctrl #(
    parameter int MAX_BUTTONS = 32,
    localparam int BTN_BYTES  = (MAX_BUTTONS + 7) / 8,
    localparam int BIW        = (BTN_BYTES > 1) ? $clog2(BTN_BYTES) : 1,
    localparam int NBW        = $clog2(BTN_BYTES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          action,
    input  logic                upd_ok,
    input  logic                auto_send,
    input  logic [5:0]          button_count,
    input  logic [1:0]          hat_count,
    input  logic [10:0]         axis_mask,
    output logic                busy,
    output logic [BIW-1:0]      btn_sel,
    output hjrb_pkg::hjrb_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_BTN   = 9'b000000010,
        ST_HAT   = 9'b000000100,
        ST_AXSEL = 9'b000001000,
        ST_PREP  = 9'b000010000,
        ST_LOAD  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_LO    = 9'b010000000,
        ST_HI    = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [NBW-1:0]              btn_cnt_reg, btn_cnt_next;
    logic [hjrb_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [10:0]                 pend_reg, pend_next;
    logic [3:0]                  div_cnt_reg, div_cnt_next;

    logic [3:0]     nbytes_raw;
    logic [NBW-1:0] nbytes;
    logic           hat_present;
    logic           btn_last;
    logic           accept;
    logic           send_now;

    always_comb
    begin
        nbytes_raw = 4'((7'(button_count) + 7'd7) >> 3);
        if (int'(nbytes_raw) > BTN_BYTES)
            nbytes = NBW'(BTN_BYTES);
        else
            nbytes = NBW'(nbytes_raw);
        hat_present = (hat_count != 2'd0);
        btn_last    = ((btn_cnt_reg + NBW'(1)) == nbytes);
        accept      = start && (state_reg == ST_IDLE);
        send_now    = (action == hjrb_pkg::ACT_SEND) || (auto_send && upd_ok);
    end

    always_comb
    begin
        state_next   = state_reg;
        btn_cnt_next = btn_cnt_reg;
        slot_next    = slot_reg;
        pend_next    = pend_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.src      = hjrb_pkg::SRC_BUTTON;
        cmd.slot     = slot_reg;
        cmd.accept   = accept;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && send_now)
                begin
                    btn_cnt_next = '0;
                    slot_next    = '0;
                    pend_next    = axis_mask;
                    if (nbytes != '0)
                        state_next = ST_BTN;
                    else if (hat_present)
                        state_next = ST_HAT;
                    else
                        state_next = ST_AXSEL;
                end
            end
            ST_BTN:
            begin
                cmd.emit = 1'b1;
                cmd.src  = hjrb_pkg::SRC_BUTTON;
                cmd.last = btn_last && !hat_present && (axis_mask == '0);
                if (btn_last)
                begin
                    if (hat_present)
                        state_next = ST_HAT;
                    else if (axis_mask == '0)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_AXSEL;
                end
                else
                    btn_cnt_next = btn_cnt_reg + NBW'(1);
            end
            ST_HAT:
            begin
                cmd.emit   = 1'b1;
                cmd.src    = hjrb_pkg::SRC_HAT;
                cmd.last   = (axis_mask == '0);
                state_next = (axis_mask == '0) ? ST_IDLE : ST_AXSEL;
            end
            ST_AXSEL:
            begin
                if (pend_reg == '0)
                    state_next = ST_IDLE;
                else if (pend_reg[0])
                    state_next = ST_PREP;
                else
                begin
                    pend_next = pend_reg >> 1;
                    slot_next = slot_reg + hjrb_pkg::SLOT_W'(1);
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                    state_next = ST_LO;
            end
            ST_LO:
            begin
                cmd.emit   = 1'b1;
                cmd.src    = hjrb_pkg::SRC_AXIS_LO;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                cmd.emit   = 1'b1;
                cmd.src    = hjrb_pkg::SRC_AXIS_HI;
                cmd.last   = (pend_reg[10:1] == '0);
                pend_next  = pend_reg >> 1;
                slot_next  = slot_reg + hjrb_pkg::SLOT_W'(1);
                state_next = (pend_reg[10:1] == '0) ? ST_IDLE : ST_AXSEL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            btn_cnt_reg <= '0;
            slot_reg    <= '0;
            pend_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            btn_cnt_reg <= btn_cnt_next;
            slot_reg    <= slot_next;
            pend_reg    <= pend_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign btn_sel = btn_cnt_reg[BIW-1:0];

endmodule

### rtl/core/hid_joystick_report_builder.sv
// ----------------------------------------------------------------------------
// hid_joystick_report_builder: joystick HID input report generator
// Command-driven store of buttons, hats and axes that streams out a joystick
// input report one byte per strobe.
// ----------------------------------------------------------------------------
// A command is taken when start is high while busy is low. Button, axis and
// hat updates are stored at once; with auto_send set, a valid update (and any
// send command) starts a report, and busy stays high until its last byte has
// been issued. Range updates and invalid indexes never produce a report and
// leave busy low. Report bytes appear on report_byte for exactly one cycle
// each, flagged by report_valid, with last_byte on the final one; the
// receiver has no way to stall them. A report walks the button bytes, the hat
// byte, and then each axis slot up to the last enabled one, taking a select
// step per slot; an enabled axis adds clamp, load, 16 divider steps and two
// bytes. The per-axis cost is set by the restoring divider, which retires
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hid_joystick_report_builder #(
    parameter int MAX_BUTTONS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command transaction
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      action,
    input  logic [4:0]                      index,
    input  logic signed [15:0]              value,
    input  logic signed [15:0]              range_end,
    // report bytes
    output logic                            report_valid,
    output logic [7:0]                      report_byte,
    output logic                            last_byte,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hjrb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int BTN_BYTES = (MAX_BUTTONS + 7) / 8;
    localparam int BIW       = (BTN_BYTES > 1) ? $clog2(BTN_BYTES) : 1;

    logic [5:0]  button_count_reg;
    logic [1:0]  hat_count_reg;
    logic [10:0] axis_mask_reg;
    logic        auto_send_reg;

    logic                cfg_wr;
    logic                upd_ok;
    logic [BIW-1:0]      btn_sel;
    hjrb_pkg::hjrb_cmd_t cmd;

    // configuration registers: written on the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= hjrb_pkg::BUTTON_COUNT_RST;
            hat_count_reg    <= hjrb_pkg::HAT_COUNT_RST;
            axis_mask_reg    <= hjrb_pkg::AXIS_MASK_RST;
            auto_send_reg    <= hjrb_pkg::AUTO_SEND_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                hjrb_pkg::REG_BUTTON_COUNT: button_count_reg <= pwdata[5:0];
                hjrb_pkg::REG_HAT_COUNT:    hat_count_reg    <= pwdata[1:0];
                hjrb_pkg::REG_AXIS_MASK:    axis_mask_reg    <= pwdata[10:0];
                hjrb_pkg::REG_AUTO_SEND:    auto_send_reg    <= pwdata[0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            hjrb_pkg::REG_BUTTON_COUNT: prdata = {26'd0, button_count_reg};
            hjrb_pkg::REG_HAT_COUNT:    prdata = {30'd0, hat_count_reg};
            hjrb_pkg::REG_AXIS_MASK:    prdata = {21'd0, axis_mask_reg};
            hjrb_pkg::REG_AUTO_SEND:    prdata = {31'd0, auto_send_reg};
            default:                    prdata = '0;
        endcase
    end

    // sequencer: owns busy, walks the report layout
    hjrb_ctrl #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .upd_ok       (upd_ok),
        .auto_send    (auto_send_reg),
        .button_count (button_count_reg),
        .hat_count    (hat_count_reg),
        .axis_mask    (axis_mask_reg),
        .busy         (busy),
        .btn_sel      (btn_sel),
        .cmd          (cmd)
    );

    // storage, axis scaling and output register
    hjrb_datapath #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .btn_sel      (btn_sel),
        .action       (action),
        .index        (index),
        .value        (value),
        .range_end    (range_end),
        .button_count (button_count_reg),
        .hat_count    (hat_count_reg),
        .upd_ok       (upd_ok),
        .report_byte  (report_byte),
        .last_byte    (last_byte),
        .report_valid (report_valid)
    );

    // bytes only come out of a transaction that was in progress
    a_valid_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> $past(busy))
        else $error("report byte issued without a report in progress");

    // the final byte closes the report
    a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && last_byte) |-> !busy)
        else $error("sequencer still busy after final report byte");

    // range updates never start a report
    a_range_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == hjrb_pkg::ACT_SET_RANGE)) |=> !busy)
        else $error("range update started a report");

    // without auto-send only the send command starts a report
    a_no_auto_send: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !auto_send_reg && (action != hjrb_pkg::ACT_SEND)) |=> !busy)
        else $error("update started a report with auto-send off");

endmodule
